FILE: hdl/assert_macros.svh
// Assertion helpers; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

FILE: hdl/crfab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfab_pkg
// Shared constants and types of the rectangle fill / alpha blit engine.
// ----------------------------------------------------------------------------
package crfab_pkg;
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int ATLAS_W    = 128;
   localparam int ATLAS_H    = 128;
   localparam int FB_AW  = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT);
   localparam int AT_AW  = $clog2(ATLAS_W) + $clog2(ATLAS_H);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int UW     = $clog2(ATLAS_W);
   localparam int VW     = $clog2(ATLAS_H);

   localparam logic [2:0] REQ_CLEAR = 3'd0;
   localparam logic [2:0] REQ_FILL  = 3'd1;
   localparam logic [2:0] REQ_BLIT  = 3'd2;
   localparam logic [2:0] REQ_CLIP  = 3'd3;
   localparam logic [2:0] REQ_TEXEL = 3'd4;
   localparam logic [2:0] REQ_READ  = 3'd5;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // request payload, highest field first (req_type in the lowest bits)
   typedef struct packed {
      logic [7:0]  texel_alpha;
      logic [23:0] fill_color;
      logic [7:0]  src_h;
      logic [7:0]  src_w;
      logic [6:0]  src_y;
      logic [6:0]  src_x;
      logic [10:0] dst_h;
      logic [10:0] dst_w;
      logic [11:0] dst_y;
      logic [11:0] dst_x;
      logic [2:0]  req_type;
   } req_type_type;
endpackage

FILE: hdl/crfab_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crfab_ram
// Single-port RAM, one access per cycle, registered read data; a write also reads the old word.
// ----------------------------------------------------------------------------
module crfab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

FILE: hdl/clipped_rect_fill_and_alpha_blit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rect_fill_and_alpha_blit
// 2D engine: clear, clipped fill, centered alpha blit, clip set, atlas write,
// pixel read over an RGB888 frame store and an 8-bit alpha atlas.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req_    | in  | one drawing command (kind on tuser)
//  rsp_    | out | pixel_value, addr_error (one per command)
//  csr_    | in  | screen_width (0), screen_height (1)
// Clear/fill: after S_SETUP and S_BOX, S_FILL writes each covered pixel in turn.
// Blit: per covered pixel, atlas read, frame read, three channel blends
// through one shared multiplier, then write.
// req_tready is low while busy.
// Reset is synchronous; the memories need no clearing.
`include "assert_macros.svh"
module clipped_rect_fill_and_alpha_blit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // dst_x, dst_y, dst_w, dst_h, src_x, src_y, src_w, src_h,
   // fill_color, texel_alpha (108 bits, padded to 112)
   input  logic [111:0] req_tdata,
   // req_type
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_value, addr_error (25 bits, padded to 32)
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);
   import crfab_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SETUP = 4'd1;
   localparam logic [3:0] S_BOX   = 4'd2;
   localparam logic [3:0] S_FILL  = 4'd3;
   localparam logic [3:0] S_ARD   = 4'd4;
   localparam logic [3:0] S_FRD   = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_WR    = 4'd7;
   localparam logic [3:0] S_RD    = 4'd8;
   localparam logic [3:0] S_RDW   = 4'd9;
   localparam logic [3:0] S_RSP   = 4'd10;

   req_type_type rq_ff;
   logic [3:0]  state_ff, state_in;
   logic [8:0]  sw_ff, sh_ff;
   logic signed [13:0] cl_ff, ct_ff, cw_ff, ch_ff;
   logic signed [13:0] bx_ff, by_ff;
   logic signed [13:0] xs_ff, xe_ff, ys_ff, ye_ff, x_ff, y_ff;
   logic [23:0] pix_ff, acc_ff;
   logic        err_ff, rv_ff;
   logic [7:0]  a_ff;
   logic [1:0]  ch_sel_ff;

   logic signed [13:0] ew, eh;
   assign ew = (sw_ff > 9'(MAX_WIDTH))  ? 14'(MAX_WIDTH)  : 14'(sw_ff);
   assign eh = (sh_ff > 9'(MAX_HEIGHT)) ? 14'(MAX_HEIGHT) : 14'(sh_ff);

   // memories
   logic          fb_we;
   logic [FB_AW-1:0] fb_addr;
   logic [23:0]   fb_wd, fb_rd;
   logic          at_we;
   logic [AT_AW-1:0] at_addr;
   logic [7:0]    at_rd;

   crfab_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_frame (
      .clock(clock), .wr_en(fb_we), .addr(fb_addr), .wr_data(fb_wd), .rd_data(fb_rd));
   crfab_ram #(.WIDTH(8), .DEPTH(ATLAS_W * ATLAS_H)) u_atlas (
      .clock(clock), .wr_en(at_we), .addr(at_addr), .wr_data(rq_ff.texel_alpha),
      .rd_data(at_rd));

   logic signed [13:0] u_s, v_s;
   assign u_s = 14'(rq_ff.src_x) + x_ff - bx_ff;
   assign v_s = 14'(rq_ff.src_y) + y_ff - by_ff;
   logic atlas_ok;
   assign atlas_ok = (u_s < 14'(ATLAS_W)) && (v_s < 14'(ATLAS_H));

   always_comb begin
      fb_we = 1'b0;
      fb_wd = rq_ff.fill_color;
      at_we = 1'b0;
      fb_addr = {y_ff[YW-1:0], x_ff[XW-1:0]};
      at_addr = {v_s[VW-1:0], u_s[UW-1:0]};
      unique case (state_ff)
         S_FILL: fb_we = 1'b1;
         S_WR: begin
            fb_we = 1'b1;
            fb_wd = acc_ff;
         end
         S_SETUP: begin
            at_we = (rq_ff.req_type == REQ_TEXEL);
            at_addr = {rq_ff.src_y[VW-1:0], rq_ff.src_x[UW-1:0]};
         end
         S_RD: fb_addr = {rq_ff.dst_y[YW-1:0], rq_ff.dst_x[XW-1:0]};
         default: ;
      endcase
   end

   // shared blend unit: one channel per cycle, c1 + (c2-c1)*a/255
   logic [7:0] c1, c2;
   logic signed [17:0] prod;
   logic [16:0] mag;
   logic [8:0]  q;
   logic [7:0]  bres;
   always_comb begin
      unique case (ch_sel_ff)
         2'd0: begin c1 = fb_rd[7:0];   c2 = rq_ff.fill_color[7:0];   end
         2'd1: begin c1 = fb_rd[15:8];  c2 = rq_ff.fill_color[15:8];  end
         default: begin c1 = fb_rd[23:16]; c2 = rq_ff.fill_color[23:16]; end
      endcase
      prod = (18'(signed'({1'b0, c2})) - 18'(signed'({1'b0, c1}))) * 18'(signed'({1'b0, a_ff}));
      mag  = prod[17] ? 17'(-prod) : prod[16:0];
      // x/255 for x < 65536: (x + 1 + (x>>8)) >> 8
      q    = 9'((25'(mag) + 25'd1 + 25'(mag >> 8)) >> 8);
      bres = prod[17] ? 8'(c1 - q[7:0]) : 8'(c1 + q[7:0]);
   end

   logic rsp_go;
   assign rsp_go = rsp_tvalid && rsp_tready;

   logic signed [13:0] xs_c, xe_c, ys_c, ye_c, lim_x, lim_y;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_SETUP;
         S_SETUP: begin
            unique case (rq_ff.req_type)
               REQ_CLEAR, REQ_FILL, REQ_BLIT: state_in = S_BOX;
               REQ_READ: state_in = S_RD;
               default: state_in = S_RSP;
            endcase
         end
         S_BOX: state_in = (xs_c < xe_c && ys_c < ye_c) ?
                           ((rq_ff.req_type == REQ_BLIT) ? S_ARD : S_FILL) : S_RSP;
         S_FILL, S_WR: begin
            if (x_ff + 14'sd1 < xe_ff) state_in = (state_ff == S_FILL) ? S_FILL : S_ARD;
            else if (y_ff + 14'sd1 < ye_ff) state_in = (state_ff == S_FILL) ? S_FILL : S_ARD;
            else state_in = S_RSP;
         end
         S_ARD: state_in = S_FRD;
         S_FRD: state_in = S_MUL;
         S_MUL: if (ch_sel_ff == 2'd2) state_in = S_WR;
         S_RD:  state_in = S_RDW;
         S_RDW: state_in = S_RSP;
         S_RSP: if (rsp_go || !rv_ff) state_in = rv_ff ? S_IDLE : S_RSP;
         default: state_in = S_IDLE;
      endcase
   end

   logic signed [13:0] box_x, box_y, box_w, box_h;
   always_comb begin
      box_x = 14'(signed'(rq_ff.dst_x));
      box_y = 14'(signed'(rq_ff.dst_y));
      box_w = 14'(rq_ff.dst_w);
      box_h = 14'(rq_ff.dst_h);
      if (rq_ff.req_type == REQ_CLEAR) begin
         box_x = '0; box_y = '0; box_w = ew; box_h = eh;
      end else if (rq_ff.req_type == REQ_BLIT) begin
         box_x = bx_ff; box_y = by_ff;
         box_w = 14'(rq_ff.src_w); box_h = 14'(rq_ff.src_h);
      end
   end

   function automatic logic signed [13:0] half_t(input logic signed [13:0] v);
      logic signed [13:0] t;
      t = v + (v[13] ? 14'sd1 : 14'sd0);
      return t >>> 1;
   endfunction

   always_comb begin
      lim_x = (rq_ff.req_type == REQ_CLEAR) ? ew :
              ((cl_ff + cw_ff < ew) ? cl_ff + cw_ff : ew);
      lim_y = (rq_ff.req_type == REQ_CLEAR) ? eh :
              ((ct_ff + ch_ff < eh) ? ct_ff + ch_ff : eh);
      xs_c = (rq_ff.req_type == REQ_CLEAR || box_x > cl_ff) ? box_x : cl_ff;
      if (xs_c < 0) xs_c = '0;
      ys_c = (rq_ff.req_type == REQ_CLEAR || box_y > ct_ff) ? box_y : ct_ff;
      if (ys_c < 0) ys_c = '0;
      xe_c = (box_x + box_w < lim_x) ? box_x + box_w : lim_x;
      ye_c = (box_y + box_h < lim_y) ? box_y + box_h : lim_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sw_ff <= 9'd256; sh_ff <= 9'd256;
         cl_ff <= '0; ct_ff <= '0; cw_ff <= 14'sd256; ch_ff <= 14'sd256;
         rv_ff <= 1'b0;
         ch_sel_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_WIDTH) sw_ff <= csr_wdata;
            else sh_ff <= csr_wdata;
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid) rq_ff <= req_type_type'({req_tdata[107:0], req_tuser});
            S_SETUP: begin
               pix_ff <= '0; err_ff <= 1'b0;
               bx_ff <= 14'(signed'(rq_ff.dst_x)) +
                        half_t(14'(rq_ff.dst_w) - 14'(rq_ff.src_w));
               by_ff <= 14'(signed'(rq_ff.dst_y)) +
                        half_t(14'(rq_ff.dst_h) - 14'(rq_ff.src_h));
               if (rq_ff.req_type == REQ_CLIP) begin
                  cl_ff <= 14'(signed'(rq_ff.dst_x));
                  ct_ff <= 14'(signed'(rq_ff.dst_y));
                  cw_ff <= (14'(rq_ff.dst_w) < ew) ? 14'(rq_ff.dst_w) : ew;
                  ch_ff <= (14'(rq_ff.dst_h) < eh) ? 14'(rq_ff.dst_h) : eh;
               end
            end
            S_BOX: begin
               xs_ff <= xs_c; xe_ff <= xe_c; ys_ff <= ys_c; ye_ff <= ye_c;
               x_ff <= xs_c; y_ff <= ys_c;
            end
            S_FILL, S_WR: begin
               if (x_ff + 14'sd1 < xe_ff) x_ff <= x_ff + 14'sd1;
               else begin
                  x_ff <= xs_ff;
                  y_ff <= y_ff + 14'sd1;
               end
            end
            S_FRD: begin
               a_ff <= atlas_ok ? at_rd : 8'd0;
               ch_sel_ff <= '0;
            end
            S_MUL: begin
               unique case (ch_sel_ff)
                  2'd0: acc_ff[7:0]   <= bres;
                  2'd1: acc_ff[15:8]  <= bres;
                  default: acc_ff[23:16] <= bres;
               endcase
               ch_sel_ff <= (ch_sel_ff == 2'd2) ? 2'd0 : ch_sel_ff + 2'd1;
            end
            S_RD: begin
               if (rq_ff.dst_x[11] || rq_ff.dst_y[11] ||
                   14'(signed'(rq_ff.dst_x)) >= ew || 14'(signed'(rq_ff.dst_y)) >= eh)
                  err_ff <= 1'b1;
            end
            S_RDW: if (!err_ff) pix_ff <= fb_rd;
            S_RSP: begin
               if (!rv_ff) rv_ff <= 1'b1;
               else if (rsp_go) rv_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {7'd0, err_ff, pix_ff};

   `ASSERT_NEVER(a_rsp_only_in_rsp, rv_ff && state_ff != S_RSP)
   `ASSERT_NEVER(a_ready_busy, req_tready && rv_ff)
   `ASSERT_CLK(a_accept_setup, (req_tvalid && req_tready) |=> state_ff == S_SETUP)
endmodule
